// ===== design/srlm_pkg.sv =====
// Shared types and constants of the serial register link master.
`default_nettype none
package srlm_pkg;

    // Item codes of the input channel.
    localparam logic [2:0] OP_BEGIN_WR = 3'd0;
    localparam logic [2:0] OP_WORD     = 3'd1;
    localparam logic [2:0] OP_BEGIN_RD = 3'd2;
    localparam logic [2:0] OP_RX       = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    // Kinds of result beats.
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_OWN_STATION = 3'd0;
    localparam logic [2:0] REG_WRITE_CMD   = 3'd1;
    localparam logic [2:0] REG_READ_CMD    = 3'd2;
    localparam logic [2:0] REG_OK_STATUS   = 3'd3;
    localparam logic [2:0] REG_BYTE_TMO    = 3'd4;

    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int MAX_BEATS   = 5;
    localparam int BEAT_CNT_W  = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  RST_OWN_STATION = 8'd1;
    localparam logic [15:0] RST_BYTE_TMO    = 16'd25;

    typedef struct packed {
        logic [7:0]  own_station;
        logic [7:0]  write_command;
        logic [7:0]  read_command;
        logic [7:0]  ok_status;
        logic [15:0] byte_timeout;
    } t_cfg;

    // One queue entry: the whole group of beats caused by one item.
    typedef struct packed {
        logic [BEAT_CNT_W-1:0]       beats;
        logic [1:0]                  kind;
        logic [MAX_BEATS-1:0][7:0]   bytes;
        logic [15:0]                 word;
        logic                        failed;
    } t_desc;

endpackage
`default_nettype wire

// ===== design/srlm_regs.sv =====
// Configuration registers behind the APB-style port.
`default_nettype none
module srlm_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srlm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [srlm_pkg::DATA_W-1:0]  pwdata,
    output logic      [srlm_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output srlm_pkg::t_cfg                    o_cfg
);

    srlm_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[srlm_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_station   <= srlm_pkg::RST_OWN_STATION;
            r_cfg.write_command <= 8'd0;
            r_cfg.read_command  <= 8'd0;
            r_cfg.ok_status     <= 8'd0;
            r_cfg.byte_timeout  <= srlm_pkg::RST_BYTE_TMO;
        end else if (wr_en) begin
            case (reg_idx)
                srlm_pkg::REG_OWN_STATION: r_cfg.own_station   <= pwdata[7:0];
                srlm_pkg::REG_WRITE_CMD:   r_cfg.write_command <= pwdata[7:0];
                srlm_pkg::REG_READ_CMD:    r_cfg.read_command  <= pwdata[7:0];
                srlm_pkg::REG_OK_STATUS:   r_cfg.ok_status     <= pwdata[7:0];
                srlm_pkg::REG_BYTE_TMO:    r_cfg.byte_timeout  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            srlm_pkg::REG_OWN_STATION: prdata = {24'd0, r_cfg.own_station};
            srlm_pkg::REG_WRITE_CMD:   prdata = {24'd0, r_cfg.write_command};
            srlm_pkg::REG_READ_CMD:    prdata = {24'd0, r_cfg.read_command};
            srlm_pkg::REG_OK_STATUS:   prdata = {24'd0, r_cfg.ok_status};
            srlm_pkg::REG_BYTE_TMO:    prdata = {16'd0, r_cfg.byte_timeout};
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/srlm_front.sv =====
// Front end: accepts items, runs the transaction sequencer, queues beat groups.
`default_nettype none
module srlm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire srlm_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [2:0]     i_op,
    input  wire logic [7:0]     i_reg_addr,
    input  wire logic [7:0]     i_word_count,
    input  wire logic [15:0]    i_data_word,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic           i_full,
    output logic                o_push,
    output srlm_pkg::t_desc     o_desc
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_WDATA = 4'd1;
    localparam logic [3:0] PH_RSTN  = 4'd2;
    localparam logic [3:0] PH_RSTAT = 4'd3;
    localparam logic [3:0] PH_RADDR = 4'd4;
    localparam logic [3:0] PH_RLEN  = 4'd5;
    localparam logic [3:0] PH_RHI   = 4'd6;
    localparam logic [3:0] PH_RLO   = 4'd7;
    localparam logic [3:0] PH_RCK   = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic        r_is_read, n_is_read;
    logic [7:0]  r_words_left, n_words_left;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_station, n_station;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_high, n_high;
    logic [15:0] r_wait, n_wait;

    logic        accept;
    logic        waiting;
    logic        begin_rd;
    logic [7:0]  cmd_byte;
    logic [7:0]  hdr_sum;
    logic [7:0]  word_sum;
    logic [7:0]  left_dec;
    logic        bad;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign waiting  = (r_phase >= PH_RSTN) && (r_phase <= PH_RCK);
    assign begin_rd = (i_op == srlm_pkg::OP_BEGIN_RD);
    assign cmd_byte = begin_rd ? i_cfg.read_command : i_cfg.write_command;
    assign hdr_sum  = i_cfg.own_station + cmd_byte + i_reg_addr + i_word_count;
    assign word_sum = r_sum + i_data_word[15:8] + i_data_word[7:0];
    assign left_dec = r_words_left - 8'd1;
    assign bad      = (r_status != i_cfg.ok_status)
                      || (r_is_read && (r_station != i_cfg.own_station));

    always_comb begin
        n_phase      = r_phase;
        n_is_read    = r_is_read;
        n_words_left = r_words_left;
        n_sum        = r_sum;
        n_station    = r_station;
        n_status     = r_status;
        n_high       = r_high;
        n_wait       = r_wait;
        o_push       = 1'b0;
        o_desc       = '0;

        if (accept) begin
            if ((i_op == srlm_pkg::OP_BEGIN_WR || begin_rd) && r_phase == PH_IDLE) begin
                o_push         = 1'b1;
                o_desc.kind    = srlm_pkg::KIND_TX;
                o_desc.bytes[0] = i_cfg.own_station;
                o_desc.bytes[1] = cmd_byte;
                o_desc.bytes[2] = i_reg_addr;
                o_desc.bytes[3] = i_word_count;
                n_is_read      = begin_rd;
                n_words_left   = i_word_count;
                n_sum          = hdr_sum;
                if (begin_rd || i_word_count == 8'd0) begin
                    o_desc.beats    = 3'd5;
                    o_desc.bytes[4] = hdr_sum;
                    n_phase         = PH_RSTN;
                    n_wait          = i_cfg.byte_timeout;
                end else begin
                    o_desc.beats = 3'd4;
                    n_phase      = PH_WDATA;
                end
            end else if (i_op == srlm_pkg::OP_WORD && r_phase == PH_WDATA) begin
                o_push          = 1'b1;
                o_desc.kind     = srlm_pkg::KIND_TX;
                o_desc.bytes[0] = i_data_word[15:8];
                o_desc.bytes[1] = i_data_word[7:0];
                n_sum           = word_sum;
                n_words_left    = left_dec;
                if (left_dec == 8'd0) begin
                    o_desc.beats    = 3'd3;
                    o_desc.bytes[2] = word_sum;
                    n_phase         = PH_RSTN;
                    n_wait          = i_cfg.byte_timeout;
                end else begin
                    o_desc.beats = 3'd2;
                end
            end else if (i_op == srlm_pkg::OP_RX && waiting) begin
                n_wait = i_cfg.byte_timeout;
                case (r_phase)
                    PH_RSTN: begin
                        n_station = i_rx_byte;
                        n_phase   = PH_RSTAT;
                    end
                    PH_RSTAT: begin
                        n_status = i_rx_byte;
                        n_phase  = r_is_read ? PH_RADDR : PH_RCK;
                    end
                    PH_RADDR: begin
                        n_phase = PH_RLEN;
                    end
                    PH_RLEN: begin
                        n_phase = (r_words_left != 8'd0) ? PH_RHI : PH_RCK;
                    end
                    PH_RHI: begin
                        n_high  = i_rx_byte;
                        n_phase = PH_RLO;
                    end
                    PH_RLO: begin
                        o_push       = 1'b1;
                        o_desc.beats = 3'd1;
                        o_desc.kind  = srlm_pkg::KIND_WORD;
                        o_desc.word  = {r_high, i_rx_byte};
                        n_words_left = left_dec;
                        n_phase      = (left_dec != 8'd0) ? PH_RHI : PH_RCK;
                    end
                    default: begin
                        // Checksum byte of the reply: not verified, ends the transaction.
                        o_push        = 1'b1;
                        o_desc.beats  = 3'd1;
                        o_desc.kind   = srlm_pkg::KIND_DONE;
                        o_desc.failed = bad;
                        n_phase       = PH_IDLE;
                        n_wait        = 16'd0;
                    end
                endcase
            end else if (i_op == srlm_pkg::OP_TICK && waiting) begin
                if (r_wait <= 16'd1) begin
                    o_push        = 1'b1;
                    o_desc.beats  = 3'd1;
                    o_desc.kind   = srlm_pkg::KIND_DONE;
                    o_desc.failed = 1'b1;
                    n_phase       = PH_IDLE;
                    n_wait        = 16'd0;
                end else begin
                    n_wait = r_wait - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_is_read    <= 1'b0;
            r_words_left <= 8'd0;
            r_sum        <= 8'd0;
            r_station    <= 8'd0;
            r_status     <= 8'd0;
            r_high       <= 8'd0;
            r_wait       <= 16'd0;
        end else begin
            r_phase      <= n_phase;
            r_is_read    <= n_is_read;
            r_words_left <= n_words_left;
            r_sum        <= n_sum;
            r_station    <= n_station;
            r_status     <= n_status;
            r_high       <= n_high;
            r_wait       <= n_wait;
        end
    end

endmodule
`default_nettype wire

// ===== design/srlm_queue.sv =====
// Short queue of beat groups between the front end and the output sequencer.
`default_nettype none
module srlm_queue #(
    parameter int DEPTH = srlm_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire srlm_pkg::t_desc i_desc,
    input  wire logic            i_pop,
    output srlm_pkg::t_desc      o_desc,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    srlm_pkg::t_desc  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/srlm_back.sv =====
// Output sequencer: plays one beat group out, one beat per accepted cycle.
`default_nettype none
module srlm_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire srlm_pkg::t_desc i_desc,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_tx_byte,
    output logic [15:0]          o_read_word,
    output logic                 o_failed,
    output logic                 o_last
);

    srlm_pkg::t_desc               r_desc;
    logic                          r_busy;
    logic [srlm_pkg::BEAT_CNT_W-1:0] r_idx;
    logic                          accept;
    logic                          load;

    assign o_valid     = r_busy;
    assign o_last      = (r_idx == r_desc.beats - 1'b1);
    assign o_kind      = r_desc.kind;
    assign o_tx_byte   = r_desc.bytes[r_idx];
    assign o_read_word = r_desc.word;
    assign o_failed    = r_desc.failed;
    assign accept      = r_busy && !i_stall;
    // The next group is taken in the cycle the last beat of the current one leaves.
    assign load        = !r_busy || (accept && o_last);
    assign o_pop       = load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= !i_empty;
            r_idx  <= '0;
        end else if (accept) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== design/serial_register_link_master.sv =====
// Top level of the serial register link master.
// Input channel (i_valid / o_stall): one item per beat, op selects begin write,
// write word, begin read, received byte or timer tick; other fields ride along.
// Output channel (o_valid / i_stall): one result per beat, o_last marks the
// final beat caused by an input item. A begin item gives four or five transmit
// bytes, a write word two or three, a reply byte or tick at most one.
// An accepted item goes into the beat-group queue; its first beat appears once the
// output sequencer has loaded it. The sequencer sends one beat per cycle while the
// receiver does not stall; the front end takes one item per cycle as long as the
// beat-group queue has room.
// Configuration goes through the APB-style port; writes complete in the access
// cycle and pready is always high. Registers should be changed only while idle.
// Reset (synchronous, active low) returns the sequencer to idle, empties the
// queue and loads the register defaults. While the receiver stalls, the current
// beat holds and the queue fills; o_stall rises once the queue is full.
`default_nettype none
module serial_register_link_master #(
    parameter int QUEUE_DEPTH = srlm_pkg::QUEUE_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srlm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [srlm_pkg::DATA_W-1:0]  pwdata,
    output logic      [srlm_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [2:0]                   i_op,
    input  wire logic [7:0]                   i_reg_addr,
    input  wire logic [7:0]                   i_word_count,
    input  wire logic [15:0]                  i_data_word,
    input  wire logic [7:0]                   i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_kind,
    output logic [7:0]                        o_tx_byte,
    output logic [15:0]                       o_read_word,
    output logic                              o_failed,
    output logic                              o_last
);

    srlm_pkg::t_cfg  cfg;
    srlm_pkg::t_desc push_desc;
    srlm_pkg::t_desc head_desc;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    srlm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    srlm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_reg_addr   (i_reg_addr),
        .i_word_count (i_word_count),
        .i_data_word  (i_data_word),
        .i_rx_byte    (i_rx_byte),
        .i_full       (q_full),
        .o_push       (push),
        .o_desc       (push_desc)
    );

    srlm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_desc  (head_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    srlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (head_desc),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_read_word (o_read_word),
        .o_failed    (o_failed),
        .o_last      (o_last)
    );

    // Word and done results are single-beat groups.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == srlm_pkg::KIND_TX || o_last))
        else $error("word or done result not marked last");

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("push into full queue");

    // A waiting group follows the last beat of the current one without a gap.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last && !q_empty) |=> o_valid)
        else $error("output bubble with queued results");

    // Transmit beats only carry bytes, never word or failure bits.
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == srlm_pkg::KIND_TX) |-> (o_read_word == 16'd0 && !o_failed))
        else $error("transmit beat carries stray fields");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the serial register link master: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD = 150;
    localparam int SETTLE_CYCLES = 10;
    localparam int ITEMS_PER_SETTING = 18;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef enum logic [3:0] {
        LK_IDLE, LK_WDATA, LK_STN, LK_STAT, LK_ADDR, LK_LEN, LK_HI, LK_LO, LK_CK
    } t_link_phase;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  addr;
        logic [7:0]  cnt;
        logic [15:0] word;
        logic [7:0]  rx;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [15:0] word;
        logic        failed;
        logic        last;
    } t_beat;

    // A directed row; where pin is set, the final beat of the item is typed in here.
    typedef struct packed {
        t_item       item;
        logic        pin;
        logic [1:0]  pin_kind;
        logic [15:0] pin_data;
        logic        pin_failed;
    } t_row;

    localparam t_row DIRECTED [26] = '{
        '{'{srlm_pkg::OP_BEGIN_WR, 8'h00, 8'h00, 16'h0000, 8'h00},
          1'b1, srlm_pkg::KIND_TX,   16'h0001, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h01},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'hFF},
          1'b1, srlm_pkg::KIND_DONE, 16'h0000, 1'b0},
        '{'{srlm_pkg::OP_BEGIN_RD, 8'hFF, 8'h01, 16'h0000, 8'h00},
          1'b1, srlm_pkg::KIND_TX,   16'h0001, 1'b0},
        '{'{srlm_pkg::OP_BEGIN_WR, 8'h12, 8'h03, 16'h0000, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_WORD,     8'h00, 8'h00, 16'h1234, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h01},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_TICK,     8'h00, 8'h00, 16'h0000, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'hAB},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h01},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'hFF},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'hFF},
          1'b1, srlm_pkg::KIND_WORD, 16'hFFFF, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h00},
          1'b1, srlm_pkg::KIND_DONE, 16'h0000, 1'b0},
        '{'{OP_UNUSED,             8'hFF, 8'hFF, 16'hFFFF, 8'hFF},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_WORD,     8'h00, 8'h00, 16'hFFFF, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'hFF},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_TICK,     8'h00, 8'h00, 16'h0000, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_BEGIN_WR, 8'h5A, 8'h02, 16'h0000, 8'h00},
          1'b1, srlm_pkg::KIND_TX,   16'h0002, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h3C},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_WORD,     8'h00, 8'h00, 16'hFFFF, 8'h00},
          1'b1, srlm_pkg::KIND_TX,   16'h00FF, 1'b0},
        '{'{srlm_pkg::OP_WORD,     8'h00, 8'h00, 16'h0000, 8'h00},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h01},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h55},
          1'b0, srlm_pkg::KIND_TX,   16'h0000, 1'b0},
        '{'{srlm_pkg::OP_RX,       8'h00, 8'h00, 16'h0000, 8'h00},
          1'b1, srlm_pkg::KIND_DONE, 16'h0000, 1'b1}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [srlm_pkg::ADDR_W-1:0] paddr;
    logic [srlm_pkg::DATA_W-1:0] pwdata;
    logic [srlm_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        i_valid;
    logic                        o_stall;
    logic [2:0]                  i_op;
    logic [7:0]                  i_reg_addr;
    logic [7:0]                  i_word_count;
    logic [15:0]                 i_data_word;
    logic [7:0]                  i_rx_byte;
    logic                        o_valid;
    logic                        i_stall;
    logic [1:0]                  o_kind;
    logic [7:0]                  o_tx_byte;
    logic [15:0]                 o_read_word;
    logic                        o_failed;
    logic                        o_last;

    serial_register_link_master uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_op(i_op), .i_reg_addr(i_reg_addr),
        .i_word_count(i_word_count), .i_data_word(i_data_word), .i_rx_byte(i_rx_byte),
        .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind), .o_tx_byte(o_tx_byte),
        .o_read_word(o_read_word), .o_failed(o_failed), .o_last(o_last)
    );

    // Mirror of the link: register settings and transaction state.
    srlm_pkg::t_cfg link_cfg;
    t_link_phase    lk_phase;
    logic           lk_read;
    logic [7:0]     lk_left;
    logic [7:0]     lk_sum;
    logic [7:0]     lk_station;
    logic [7:0]     lk_status;
    logic [7:0]     lk_high;
    logic [15:0]    lk_wait;

    t_beat beats_due [$];
    int    errors = 0;
    bit    hold_long = 1'b0;
    bit    lose_reply = 1'b0;
    bit    tx_calm = 1'b0;
    int    crowd_left = 0;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_beat(logic [1:0] kind, logic [7:0] tx, logic [15:0] word,
                                     logic failed);
        beats_due.push_back(t_beat'{kind, tx, word, failed, 1'b0});
    endfunction

    function automatic void send_byte(logic [7:0] b);
        lk_sum = lk_sum + b;
        add_beat(srlm_pkg::KIND_TX, b, 16'h0000, 1'b0);
    endfunction

    function automatic void await_byte(t_link_phase next);
        lk_phase = next;
        lk_wait = link_cfg.byte_timeout;
    endfunction

    // Advances the mirror by one accepted item and queues the beats it causes.
    function automatic int link_step(input t_item it, output bit took);
        int    before_cnt;
        t_beat b;
        logic  bad;
        before_cnt = beats_due.size();
        took = 1'b0;
        if ((it.op == srlm_pkg::OP_BEGIN_WR || it.op == srlm_pkg::OP_BEGIN_RD)
            && lk_phase == LK_IDLE) begin
            took = 1'b1;
            lk_read = (it.op == srlm_pkg::OP_BEGIN_RD);
            lk_sum = 8'h00;
            lk_left = it.cnt;
            send_byte(link_cfg.own_station);
            send_byte(lk_read ? link_cfg.read_command : link_cfg.write_command);
            send_byte(it.addr);
            send_byte(it.cnt);
            if (lk_read || it.cnt == 8'h00) begin
                add_beat(srlm_pkg::KIND_TX, lk_sum, 16'h0000, 1'b0);
                await_byte(LK_STN);
            end else begin
                lk_phase = LK_WDATA;
            end
        end else if (it.op == srlm_pkg::OP_WORD && lk_phase == LK_WDATA) begin
            took = 1'b1;
            send_byte(it.word[15:8]);
            send_byte(it.word[7:0]);
            lk_left = lk_left - 8'd1;
            if (lk_left == 8'h00) begin
                add_beat(srlm_pkg::KIND_TX, lk_sum, 16'h0000, 1'b0);
                await_byte(LK_STN);
            end
        end else if (it.op == srlm_pkg::OP_RX && lk_phase >= LK_STN) begin
            took = 1'b1;
            case (lk_phase)
                LK_STN: begin
                    lk_station = it.rx;
                    await_byte(LK_STAT);
                end
                LK_STAT: begin
                    lk_status = it.rx;
                    if (lk_read) await_byte(LK_ADDR);
                    else await_byte(LK_CK);
                end
                LK_ADDR: await_byte(LK_LEN);
                LK_LEN: begin
                    if (lk_left != 8'h00) await_byte(LK_HI);
                    else await_byte(LK_CK);
                end
                LK_HI: begin
                    lk_high = it.rx;
                    await_byte(LK_LO);
                end
                LK_LO: begin
                    add_beat(srlm_pkg::KIND_WORD, 8'h00, {lk_high, it.rx}, 1'b0);
                    lk_left = lk_left - 8'd1;
                    if (lk_left != 8'h00) await_byte(LK_HI);
                    else await_byte(LK_CK);
                end
                default: begin
                    // The reply checksum itself is never verified.
                    bad = (lk_status != link_cfg.ok_status) ||
                          (lk_read && lk_station != link_cfg.own_station);
                    add_beat(srlm_pkg::KIND_DONE, 8'h00, 16'h0000, bad);
                    lk_phase = LK_IDLE;
                    lk_wait = 16'h0000;
                end
            endcase
        end else if (it.op == srlm_pkg::OP_TICK && lk_phase >= LK_STN) begin
            took = 1'b1;
            if (lk_wait <= 16'd1) begin
                lk_wait = 16'h0000;
                lk_phase = LK_IDLE;
                add_beat(srlm_pkg::KIND_DONE, 8'h00, 16'h0000, 1'b1);
            end else begin
                lk_wait = lk_wait - 16'd1;
            end
        end
        if (beats_due.size() > before_cnt) begin
            b = beats_due.pop_back();
            b.last = 1'b1;
            beats_due.push_back(b);
        end
        return beats_due.size() - before_cnt;
    endfunction

    function automatic int next_gap();
        if ($urandom_range(0, 11) == 0) tx_calm = !tx_calm;
        if (crowd_left > 0) begin
            crowd_left--;
            return 0;
        end
        return tx_calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Mostly well-formed traffic that follows the link state, with some stray items.
    function automatic void pick_item(output t_item it);
        it.op = 3'($urandom_range(0, 7));
        it.addr = 8'($urandom);
        it.cnt = 8'($urandom);
        it.word = 16'($urandom);
        it.rx = 8'($urandom);
        if ($urandom_range(0, 99) < 15) begin
            // Keep accidental requests short so the run keeps moving.
            if (lk_phase == LK_IDLE) it.cnt = {4'h0, it.cnt[3:0]};
            return;
        end
        case (lk_phase)
            LK_IDLE: begin
                lose_reply = (link_cfg.byte_timeout <= 16'd30) && ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 1) == 1) it.op = srlm_pkg::OP_BEGIN_RD;
                else it.op = srlm_pkg::OP_BEGIN_WR;
                // A read whose reply is lost may announce any count at all.
                if (!(lose_reply && it.op == srlm_pkg::OP_BEGIN_RD)) begin
                    if ($urandom_range(0, 7) == 0) it.cnt = 8'($urandom_range(0, 12));
                    else it.cnt = 8'($urandom_range(0, 3));
                end
            end
            LK_WDATA: it.op = srlm_pkg::OP_WORD;
            default: begin
                if (lose_reply && link_cfg.byte_timeout <= 16'd30) begin
                    it.op = srlm_pkg::OP_TICK;
                end else if (lk_wait > 16'd1 && $urandom_range(0, 4) == 0) begin
                    it.op = srlm_pkg::OP_TICK;
                end else begin
                    it.op = srlm_pkg::OP_RX;
                    if (lk_phase == LK_STN && $urandom_range(0, 9) != 0)
                        it.rx = link_cfg.own_station;
                    if (lk_phase == LK_STAT && $urandom_range(0, 7) != 0)
                        it.rx = link_cfg.ok_status;
                end
            end
        endcase
    endfunction

    task automatic send_item(input t_item it, input int gap, output int made, output bit took);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op <= it.op;
        i_reg_addr <= it.addr;
        i_word_count <= it.cnt;
        i_data_word <= it.word;
        i_rx_byte <= it.rx;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        made = link_step(it, took);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [srlm_pkg::DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic load_settings(input srlm_pkg::t_cfg s);
        write_reg(srlm_pkg::REG_OWN_STATION, {24'h0, s.own_station});
        write_reg(srlm_pkg::REG_WRITE_CMD, {24'h0, s.write_command});
        write_reg(srlm_pkg::REG_READ_CMD, {24'h0, s.read_command});
        write_reg(srlm_pkg::REG_OK_STATUS, {24'h0, s.ok_status});
        write_reg(srlm_pkg::REG_BYTE_TMO, {16'h0, s.byte_timeout});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        link_cfg = s;
    endtask

    // Items that cause no beat may still be in flight once the queue is empty.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_item          it;
        t_row           row;
        srlm_pkg::t_cfg plan [4];
        t_beat          b;
        int             made;
        int             counted;
        bit             took;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = srlm_pkg::OP_BEGIN_WR;
        i_reg_addr = 8'h00;
        i_word_count = 8'h00;
        i_data_word = 16'h0000;
        i_rx_byte = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        link_cfg = '{srlm_pkg::RST_OWN_STATION, 8'h00, 8'h00, 8'h00, srlm_pkg::RST_BYTE_TMO};
        lk_phase = LK_IDLE;
        lk_read = 1'b0;
        lk_left = 8'h00;
        lk_sum = 8'h00;
        lk_station = 8'h00;
        lk_status = 8'h00;
        lk_high = 8'h00;
        lk_wait = 16'h0000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            row = DIRECTED[r];
            send_item(row.item, next_gap(), made, took);
            if (row.pin && made > 0) begin
                b = beats_due.pop_back();
                b = t_beat'{row.pin_kind,
                            (row.pin_kind == srlm_pkg::KIND_TX) ? row.pin_data[7:0] : 8'h00,
                            (row.pin_kind == srlm_pkg::KIND_WORD) ? row.pin_data : 16'h0000,
                            row.pin_failed, 1'b1};
                beats_due.push_back(b);
            end
        end

        // Zero timeout and low extremes, high extremes, then two random settings.
        plan[0] = '{8'h00, 8'h00, 8'h00, 8'h00, 16'h0000};
        plan[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF};
        plan[2] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom_range(2, 12))};
        plan[3] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'd1};
        for (int p = 0; p < 4; p++) begin
            drain_results();
            load_settings(plan[p]);
            if (p == 2) begin
                // The receiver holds off while items keep coming back to back.
                hold_long = 1'b1;
                crowd_left = 30;
            end
            counted = 0;
            while (counted < ITEMS_PER_SETTING) begin
                pick_item(it);
                send_item(it, next_gap(), made, took);
                if (took) counted++;
            end
        end

        drain_results();
        if (errors == 0 && beats_due.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin : result_sink
        int hold;
        bit calm;
        i_stall = 1'b0;
        calm = 1'b0;
        forever begin
            if ($urandom_range(0, 11) == 0) calm = !calm;
            if (hold_long) begin
                hold = LONG_HOLD;
                hold_long = 1'b0;
            end else begin
                hold = calm ? 0 : int'($urandom_range(0, 10));
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : result_check
        t_beat got;
        t_beat want;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = t_beat'{o_kind, o_tx_byte, o_read_word, o_failed, o_last};
                if (beats_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"unexpected beat: kind %0d tx %02h word %04h",
                                  " failed %0b last %0b"},
                                 got.kind, got.tx, got.word, got.failed, got.last);
                end else begin
                    want = beats_due.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"beat mismatch: expected kind %0d tx %02h word %04h",
                                      " failed %0b last %0b"},
                                     want.kind, want.tx, want.word, want.failed, want.last);
                            $display({"                    got kind %0d tx %02h word %04h",
                                      " failed %0b last %0b"},
                                     got.kind, got.tx, got.word, got.failed, got.last);
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

endmodule
